### hw/rtl/mac_pkg.sv
// Shared types, constants and opcode codes for the x86 memory access classifier.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package mac_pkg;

    // Instruction window length in bytes (4 to 16)
    localparam int C_WINDOW_BYTES = 15;
    // One lane per possible opcode position, plus one for the position past the window
    localparam int C_NUM_LANES    = C_WINDOW_BYTES + 1;
    // A lane looks at its opcode byte and the two bytes after it
    localparam int C_NUM_BYTES    = C_WINDOW_BYTES + 3;

    // Access class bits
    localparam logic [2:0] C_ACC_R    = 3'b001;
    localparam logic [2:0] C_ACC_W    = 3'b010;
    localparam logic [2:0] C_ACC_S    = 3'b100;
    localparam logic [2:0] C_ACC_NONE = 3'b000;

    // Opcode and prefix codes
    localparam logic [7:0] C_OP_ESC_0F  = 8'h0F;
    localparam logic [7:0] C_OP_VEX3    = 8'hC4;
    localparam logic [7:0] C_OP_VEX2    = 8'hC5;
    localparam logic [7:0] C_OP_POP_RM  = 8'h8F;
    localparam logic [7:0] C_PFX_OPSZ   = 8'h66;
    localparam logic [7:0] C_PFX_REPNE  = 8'hF2;
    localparam logic [7:0] C_PFX_REP    = 8'hF3;
    localparam logic [7:0] C_PFX_LOCK   = 8'hF0;
    localparam logic [7:0] C_PFX_CS     = 8'h2E;
    localparam logic [7:0] C_PFX_SS     = 8'h36;
    localparam logic [7:0] C_PFX_DS     = 8'h3E;
    localparam logic [7:0] C_PFX_ES     = 8'h26;
    localparam logic [7:0] C_PFX_FS     = 8'h64;
    localparam logic [7:0] C_PFX_GS     = 8'h65;
    localparam logic [3:0] C_PFX_REX_HI = 4'h4;
    localparam logic [1:0] C_MOD_REG    = 2'b11;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [55:0] window_high;
        logic [63:0] window_low;
        logic        mode_32bit;
        logic        page_readable;
    } t_in_item;

    typedef struct packed {
        logic reads_memory;
        logic writes_memory;
        logic uses_stack;
        logic overlong;
    } t_out_item;

    // What one lane finds when its byte is taken as the opcode
    typedef struct packed {
        logic       pfx;     // byte is a prefix
        logic       sse;     // byte is 66, F2 or F3
        logic       is_0f;   // byte is the 0F escape
        logic       need1;   // decode reads the byte after the opcode
        logic       need2;   // decode reads the second byte after the opcode
        logic [2:0] acc;     // access class
    } t_lane_res;

endpackage

`default_nettype wire

### hw/rtl/mac_lane.sv
// One classifier lane: decodes its byte as opcode with the two following bytes.
// Depends on mac_pkg.
`default_nettype none

module mac_lane (
    input  mac_pkg::t_byte     i_op,
    input  mac_pkg::t_byte     i_b1,
    input  mac_pkg::t_byte     i_b2,
    input  logic               i_mode_32bit,
    output mac_pkg::t_lane_res o_res
);
    import mac_pkg::*;

    function automatic logic [2:0] f_class_0f(input logic [7:0] op);
        logic [2:0] c;
        c = C_ACC_NONE;
        case (op)
            8'h10, 8'h12, 8'h14, 8'h15, 8'h16, 8'h28, 8'h2A, 8'h2C, 8'h2D, 8'h2E,
            8'h2F, 8'h6E, 8'h6F, 8'h70, 8'h74, 8'h75, 8'h76, 8'hA3, 8'hAF, 8'hB6,
            8'hB7, 8'hBC, 8'hBD, 8'hBE, 8'hBF, 8'hC2: c = C_ACC_R;
            8'h11, 8'h13, 8'h17, 8'h29, 8'h2B, 8'h7E, 8'h7F, 8'hAE, 8'hC3,
            8'hE7: c = C_ACC_W;
            8'h71, 8'h72, 8'h73, 8'hA4, 8'hA5, 8'hAB, 8'hAC, 8'hAD, 8'hB0, 8'hB1,
            8'hB3, 8'hBA, 8'hBB, 8'hC0, 8'hC1, 8'hC7: c = C_ACC_R | C_ACC_W;
            default: begin
                if ((op >= 8'h50 && op <= 8'h6B) || (op >= 8'hC4 && op <= 8'hC6) ||
                    (op >= 8'hD1 && op <= 8'hD5) || (op >= 8'hD7 && op <= 8'hE5) ||
                    (op >= 8'hE8 && op <= 8'hEF) || (op >= 8'hF1 && op <= 8'hFE)) begin
                    c = C_ACC_R;
                end else if (op >= 8'h90 && op <= 8'h9F) begin
                    c = C_ACC_W;
                end
            end
        endcase
        return c;
    endfunction

    function automatic logic [2:0] f_class_modrm(input logic [7:0] op, input logic m32);
        logic [2:0] c;
        c = C_ACC_NONE;
        case (op)
            8'h00, 8'h01, 8'h08, 8'h09, 8'h10, 8'h11, 8'h18, 8'h19, 8'h20, 8'h21,
            8'h28, 8'h29, 8'h30, 8'h31, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8C, 8'hC0,
            8'hC1, 8'hC6, 8'hC7, 8'hD0, 8'hD1, 8'hD2, 8'hD3: c = C_ACC_R | C_ACC_W;
            8'h02, 8'h03, 8'h0A, 8'h0B, 8'h12, 8'h13, 8'h1A, 8'h1B, 8'h22, 8'h23,
            8'h2A, 8'h2B, 8'h32, 8'h33, 8'h38, 8'h39, 8'h3A, 8'h3B, 8'h69, 8'h6B,
            8'h84, 8'h85, 8'h8A, 8'h8B, 8'h8E: c = C_ACC_R;
            8'h63: c = m32 ? (C_ACC_R | C_ACC_W) : C_ACC_R;
            default: c = C_ACC_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] f_x87(input logic [7:0] op, input logic [2:0] rg);
        logic [2:0] c;
        c = C_ACC_W;
        case (op)
            8'hD8, 8'hDA, 8'hDC, 8'hDE: c = C_ACC_R;
            8'hD9: begin
                if (rg == 3'd0 || rg == 3'd4 || rg == 3'd5) c = C_ACC_R;
                else if (rg == 3'd1) c = C_ACC_NONE;
            end
            8'hDB: begin
                if (rg == 3'd5) c = C_ACC_R;
                else if (rg == 3'd4 || rg == 3'd6) c = C_ACC_NONE;
            end
            8'hDD: begin
                if (rg == 3'd0 || rg == 3'd4) c = C_ACC_R;
                else if (rg == 3'd5) c = C_ACC_NONE;
            end
            default: begin
                if (rg == 3'd0 || rg == 3'd4 || rg == 3'd5) c = C_ACC_R;
            end
        endcase
        return c;
    endfunction

    logic [2:0] w_cm;
    logic [2:0] w_c0f;
    logic [2:0] w_rg;
    logic       w_mem1;
    logic       w_mem2;

    assign w_cm   = f_class_modrm(i_op, i_mode_32bit);
    assign w_c0f  = f_class_0f(i_b1);
    assign w_rg   = i_b1[5:3];
    assign w_mem1 = i_b1[7:6] != C_MOD_REG;
    assign w_mem2 = i_b2[7:6] != C_MOD_REG;

    always_comb begin
        o_res     = '0;
        o_res.sse = i_op == C_PFX_OPSZ || i_op == C_PFX_REPNE || i_op == C_PFX_REP;
        o_res.pfx = o_res.sse || i_op == C_PFX_LOCK || i_op == C_PFX_CS ||
                    i_op == C_PFX_SS || i_op == C_PFX_DS || i_op == C_PFX_ES ||
                    i_op == C_PFX_FS || i_op == C_PFX_GS ||
                    (!i_mode_32bit && i_op[7:4] == C_PFX_REX_HI);

        if (i_op == C_OP_VEX3 || i_op == C_OP_VEX2) begin
            o_res.need1 = i_mode_32bit;
        end else if (w_cm != C_ACC_NONE) begin
            o_res.need1 = 1'b1;
            o_res.acc   = w_mem1 ? w_cm : C_ACC_NONE;
        end else if (i_op == 8'h06 || i_op == 8'h0E || i_op == 8'h16 || i_op == 8'h1E ||
                     i_op == 8'h60) begin
            o_res.acc = i_mode_32bit ? (C_ACC_W | C_ACC_S) : C_ACC_NONE;
        end else if (i_op == 8'h07 || i_op == 8'h17 || i_op == 8'h1F || i_op == 8'h61) begin
            o_res.acc = i_mode_32bit ? (C_ACC_R | C_ACC_S) : C_ACC_NONE;
        end else if ((i_op >= 8'h50 && i_op <= 8'h57) || i_op == 8'h68 || i_op == 8'h6A ||
                     i_op == 8'h9C || i_op == 8'hC8 || i_op == 8'hE8) begin
            o_res.acc = C_ACC_W | C_ACC_S;
        end else if ((i_op >= 8'h58 && i_op <= 8'h5F) || i_op == 8'h9D || i_op == 8'hC2 ||
                     i_op == 8'hC3 || i_op == 8'hC9 || i_op == 8'hCA || i_op == 8'hCB ||
                     i_op == 8'hCF) begin
            o_res.acc = C_ACC_R | C_ACC_S;
        end else if (i_op == 8'hA0 || i_op == 8'hA1 || i_op == 8'hA6 || i_op == 8'hA7 ||
                     i_op == 8'hAC || i_op == 8'hAD || i_op == 8'hAE || i_op == 8'hAF ||
                     i_op == 8'hD7) begin
            o_res.acc = C_ACC_R;
        end else if (i_op == 8'hA2 || i_op == 8'hA3 || i_op == 8'hA4 || i_op == 8'hA5 ||
                     i_op == 8'hAA || i_op == 8'hAB) begin
            o_res.acc = C_ACC_W;
        end else if (i_op == C_OP_ESC_0F) begin
            o_res.is_0f = 1'b1;
            o_res.need1 = 1'b1;
            if (i_b1 == 8'h00) begin
                o_res.acc = C_ACC_R;
            end else if (i_b1 == 8'h01) begin
                o_res.acc = C_ACC_W;
            end else if (i_b1 == 8'hA0 || i_b1 == 8'hA8) begin
                o_res.acc = C_ACC_W | C_ACC_S;
            end else if (i_b1 == 8'hA1 || i_b1 == 8'hA9) begin
                o_res.acc = C_ACC_R | C_ACC_S;
            end else begin
                o_res.need2 = w_c0f != C_ACC_NONE;
                o_res.acc   = w_mem2 ? w_c0f : C_ACC_NONE;
            end
        end else if ((i_op >= 8'h80 && i_op <= 8'h83) || i_op == C_OP_POP_RM ||
                     i_op == 8'hF6 || i_op == 8'hF7 || i_op == 8'hFE || i_op == 8'hFF ||
                     (i_op >= 8'hD8 && i_op <= 8'hDF)) begin
            o_res.need1 = 1'b1;
            if (i_op == C_OP_POP_RM) begin
                o_res.acc = (w_mem1 ? C_ACC_W : C_ACC_NONE) | C_ACC_R | C_ACC_S;
            end else if (!w_mem1) begin
                o_res.acc = C_ACC_NONE;
            end else if (i_op <= 8'h83) begin
                o_res.acc = C_ACC_R | ((w_rg != 3'd7) ? C_ACC_W : C_ACC_NONE);
            end else if (i_op == 8'hF6 || i_op == 8'hF7) begin
                o_res.acc = (w_rg == 3'd2 || w_rg == 3'd3) ? C_ACC_W : C_ACC_R;
            end else if (i_op == 8'hFE || i_op == 8'hFF) begin
                if (w_rg == 3'd0 || w_rg == 3'd1) o_res.acc = C_ACC_W;
                else if (w_rg == 3'd2 || w_rg == 3'd3 || w_rg == 3'd6)
                    o_res.acc = C_ACC_R | C_ACC_W | C_ACC_S;
                else o_res.acc = C_ACC_R;
            end else begin
                o_res.acc = f_x87(i_op, w_rg);
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mac_merge.sv
// Merge stage: picks the lane where the prefix run ends and forms the result beat.
// Depends on mac_pkg.
`default_nettype none

module mac_merge (
    input  mac_pkg::t_lane_res i_lane [mac_pkg::C_NUM_LANES],
    input  logic               i_page_readable,
    output mac_pkg::t_out_item o_item
);
    import mac_pkg::*;

    logic       v_found;
    logic       v_sse;
    logic       v_kill;
    logic       v_n1;
    logic       v_n2;
    logic [2:0] v_acc;
    logic       v_over;

    always_comb begin
        v_found = 1'b0;
        v_sse   = 1'b0;
        v_kill  = 1'b0;
        v_n1    = 1'b0;
        v_n2    = 1'b0;
        v_acc   = C_ACC_NONE;
        v_over  = 1'b0;
        for (int i = 0; i < C_NUM_LANES; i++) begin
            if (!v_found) begin
                if (!i_lane[i].pfx) begin
                    v_found = 1'b1;
                    // a 66/F2/F3 prefix ahead of 0F drops the whole 0F decode
                    v_kill  = i_lane[i].is_0f && v_sse;
                    v_n1    = i_lane[i].need1 && !v_kill;
                    v_n2    = i_lane[i].need2 && !v_kill;
                    v_acc   = v_kill ? C_ACC_NONE : i_lane[i].acc;
                    v_over  = (i >= C_WINDOW_BYTES) ||
                              (v_n1 && (i + 1 >= C_WINDOW_BYTES)) ||
                              (v_n2 && (i + 2 >= C_WINDOW_BYTES));
                end else begin
                    v_sse = v_sse || i_lane[i].sse;
                end
            end
        end
        o_item = '0;
        if (i_page_readable) begin
            o_item.reads_memory  = v_acc[0];
            o_item.writes_memory = v_acc[1];
            o_item.uses_stack    = v_acc[2];
            o_item.overlong      = v_over;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/x86_memory_access_classifier.sv
// Top level of the x86 memory access classifier: byte window, lanes, merge and beat registers.
// Depends on mac_pkg, mac_lane and mac_merge.
`default_nettype none

// Predecodes one x86 instruction per beat and reports whether it reads memory,
// writes memory or goes through the stack, plus an overlong flag when decoding
// needed a byte past the 15-byte window (such bytes read as zero). Legacy
// prefixes are skipped, and REX 40-4F in 64-bit mode. A classifier lane sits at
// every byte position of the window and one past it; each lane decodes its
// byte as if it were the opcode, using the next two bytes for ModRM and the 0F
// map. The lane results are registered, then the merge stage picks the lane
// where the prefix run ends and applies the 66/F2/F3-before-0F rule. The unit
// takes one beat per cycle while its input is not stalled; each result passes
// first through the lane register, then through the output register.
// Input stall rises only when both registers hold a beat and the output side
// is stalled. A page that is not readable gives an all-zero result.
module x86_memory_access_classifier (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mac_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mac_pkg::t_out_item o_out_data
);
    import mac_pkg::*;

    logic [127:0]      w_raw;
    t_byte             w_bytes [C_NUM_BYTES];
    t_lane_res         w_lane  [C_NUM_LANES];
    t_out_item         w_item;
    logic              w_accept;
    logic              w_adv_out;

    // Lane stage
    logic              r_a_valid;
    logic              n_a_valid;
    logic              r_a_page;
    t_lane_res         r_a_lane [C_NUM_LANES];

    // Output stage
    logic              r_out_valid;
    logic              n_out_valid;
    t_out_item         r_out_data;

    // Bytes past the window read as zero; the top byte of the port pair is never present
    assign w_raw = {8'h00, i_in_data.window_high, i_in_data.window_low};

    for (genvar k = 0; k < C_NUM_BYTES; k++) begin : g_bytes
        if (k < C_WINDOW_BYTES && k < 16) begin : g_in
            assign w_bytes[k] = w_raw[8*k +: 8];
        end else begin : g_zero
            assign w_bytes[k] = '0;
        end
    end

    for (genvar g = 0; g < C_NUM_LANES; g++) begin : g_lane
        mac_lane u_lane (
            .i_op         (w_bytes[g]),
            .i_b1         (w_bytes[g + 1]),
            .i_b2         (w_bytes[g + 2]),
            .i_mode_32bit (i_in_data.mode_32bit),
            .o_res        (w_lane[g])
        );
    end

    mac_merge u_merge (
        .i_lane          (r_a_lane),
        .i_page_readable (r_a_page),
        .o_item          (w_item)
    );

    // Advance the output register when it is empty or being taken
    assign w_adv_out  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_a_valid && !w_adv_out;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_a_valid = r_a_valid;
        if (w_accept) begin
            n_a_valid = 1'b1;
        end else if (w_adv_out) begin
            n_a_valid = 1'b0;
        end
        n_out_valid = w_adv_out ? r_a_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_a_valid   <= n_a_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Lane payload loads on accept, output payload when it advances; else they hold
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_lane <= w_lane;
            r_a_page <= i_in_data.page_readable;
        end
        if (w_adv_out && r_a_valid) begin
            r_out_data <= w_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTH
    // Every stack access is also a read or a write
    a_stack_has_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.uses_stack || o_out_data.reads_memory ||
                         o_out_data.writes_memory))
        else $error("stack access without read or write");

    // A beat whose page is not readable leaves as an all-zero result
    a_unreadable_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !r_a_page && w_adv_out) |=> (o_out_data == '0))
        else $error("unreadable page gave a nonzero result");

    // An accepted beat reaches the output in the cycle after the lane stage drains
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 w_adv_out |=> o_out_valid)
        else $error("accepted beat did not reach the output");
`endif

endmodule

`default_nettype wire

### tb/tb_x86_memory_access_classifier.sv
// Self-checking testbench for x86_memory_access_classifier: directed and random instruction windows.
// Depends on mac_pkg and the classifier RTL; an in-bench predictor computes each expected result.
`default_nettype none

module tb_x86_memory_access_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    import mac_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int MAX_REPORTS   = 10;
    localparam int HOLD_TRIGGER  = 400;   // accepted beats before the long receiver hold-off
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 8;

    // One entry of the stimulus queue: an instruction window, or a marker that
    // makes the sender wait until every expected result has come back
    typedef struct {
        t_in_item beat;
        bit       drain;
    } t_window_entry;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;

    t_window_entry window_queue[$];
    t_out_item     expected_access[$];

    int          errors = 0;
    int          cycles = 0;
    int          accepted_cnt = 0;
    int          gap_left = 0;
    int          burst_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          rx_style = 0;
    logic [31:0] rx_cycle = '0;
    t_out_item   want;

    x86_memory_access_classifier dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Fetch one window byte; bit 8 flags a fetch past the window (byte reads as zero)
    function automatic logic [8:0] window_byte(t_in_item it, int idx);
        logic [119:0] w;
        w = {it.window_high, it.window_low};
        if (idx >= C_WINDOW_BYTES)
            return {1'b1, 8'h00};
        return {1'b0, w[8*idx +: 8]};
    endfunction

    function automatic bit is_prefix_byte(logic [7:0] b, bit m32);
        if (b inside {C_PFX_OPSZ, C_PFX_REPNE, C_PFX_REP, C_PFX_LOCK, C_PFX_CS, C_PFX_SS,
                      C_PFX_DS, C_PFX_ES, C_PFX_FS, C_PFX_GS})
            return 1'b1;
        // REX only counts as a prefix in 64-bit code
        return !m32 && (b[7:4] == C_PFX_REX_HI);
    endfunction

    // One-byte opcodes with a ModRM whose memory form has a fixed access class
    function automatic logic [2:0] modrm_class(logic [7:0] op, bit m32);
        case (op)
            8'h00, 8'h01, 8'h08, 8'h09, 8'h10, 8'h11, 8'h18, 8'h19, 8'h20, 8'h21,
            8'h28, 8'h29, 8'h30, 8'h31, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8C, 8'hC0,
            8'hC1, 8'hC6, 8'hC7, 8'hD0, 8'hD1, 8'hD2, 8'hD3: begin
                return C_ACC_R | C_ACC_W;
            end
            8'h02, 8'h03, 8'h0A, 8'h0B, 8'h12, 8'h13, 8'h1A, 8'h1B, 8'h22, 8'h23,
            8'h2A, 8'h2B, 8'h32, 8'h33, 8'h38, 8'h39, 8'h3A, 8'h3B, 8'h69, 8'h6B,
            8'h84, 8'h85, 8'h8A, 8'h8B, 8'h8E: begin
                return C_ACC_R;
            end
            // MOVSXD in 64-bit code, ARPL (read-modify-write) in 32-bit code
            8'h63: begin
                return m32 ? (C_ACC_R | C_ACC_W) : C_ACC_R;
            end
            default: begin
                return C_ACC_NONE;
            end
        endcase
    endfunction

    // 0F-map opcodes with a ModRM: class of the memory form
    function automatic logic [2:0] map0f_class(logic [7:0] op);
        case (op)
            8'h10, 8'h12, 8'h14, 8'h15, 8'h16, 8'h28, 8'h2A, 8'h2C, 8'h2D, 8'h2E,
            8'h2F, 8'h6E, 8'h6F, 8'h70, 8'h74, 8'h75, 8'h76, 8'hA3, 8'hAF, 8'hB6,
            8'hB7, 8'hBC, 8'hBD, 8'hBE, 8'hBF, 8'hC2: begin
                return C_ACC_R;
            end
            8'h11, 8'h13, 8'h17, 8'h29, 8'h2B, 8'h7E, 8'h7F, 8'hAE, 8'hC3, 8'hE7: begin
                return C_ACC_W;
            end
            8'h71, 8'h72, 8'h73, 8'hA4, 8'hA5, 8'hAB, 8'hAC, 8'hAD, 8'hB0, 8'hB1,
            8'hB3, 8'hBA, 8'hBB, 8'hC0, 8'hC1, 8'hC7: begin
                return C_ACC_R | C_ACC_W;
            end
            default: begin
            end
        endcase
        if (op inside {[8'h50:8'h6B], [8'hC4:8'hC6], [8'hD1:8'hD5], [8'hD7:8'hE5],
                       [8'hE8:8'hEF], [8'hF1:8'hFE]})
            return C_ACC_R;
        // SETcc
        if (op inside {[8'h90:8'h9F]})
            return C_ACC_W;
        return C_ACC_NONE;
    endfunction

    // x87 escapes, memory form only
    function automatic logic [2:0] x87_class(logic [7:0] op, logic [2:0] rg);
        case (op)
            8'hD8, 8'hDA, 8'hDC, 8'hDE: begin
                return C_ACC_R;
            end
            8'hD9: begin
                if (rg inside {3'd0, 3'd4, 3'd5}) return C_ACC_R;
                if (rg == 3'd1) return C_ACC_NONE;
                return C_ACC_W;
            end
            8'hDB: begin
                if (rg == 3'd5) return C_ACC_R;
                if (rg inside {3'd4, 3'd6}) return C_ACC_NONE;
                return C_ACC_W;
            end
            8'hDD: begin
                if (rg inside {3'd0, 3'd4}) return C_ACC_R;
                if (rg == 3'd5) return C_ACC_NONE;
                return C_ACC_W;
            end
            default: begin
                if (rg inside {3'd0, 3'd4, 3'd5}) return C_ACC_R;
                return C_ACC_W;
            end
        endcase
    endfunction

    // Full predecode of one window: access class plus the overlong flag
    function automatic t_out_item classify_insn(t_in_item it);
        t_out_item  res;
        logic [8:0] f;
        logic [7:0] op;
        logic [7:0] m;
        logic [2:0] acc;
        bit         over;
        bit         sse;
        bit         m32;
        int         i;
        res = '0;
        if (!it.page_readable)
            return res;
        m32 = it.mode_32bit;
        over = 1'b0;
        sse = 1'b0;
        acc = C_ACC_NONE;
        // Skip the prefix run; a fetch past the window reads zero and ends it
        i = 0;
        f = window_byte(it, i);
        over |= f[8];
        while (is_prefix_byte(f[7:0], m32)) begin
            if (f[7:0] inside {C_PFX_OPSZ, C_PFX_REPNE, C_PFX_REP})
                sse = 1'b1;
            i++;
            f = window_byte(it, i);
            over |= f[8];
        end
        op = f[7:0];
        i++;

        if (op == C_OP_VEX3 || op == C_OP_VEX2) begin
            // 32-bit code peeks at the next byte to tell VEX from LES/LDS
            if (m32) begin
                f = window_byte(it, i);
                over |= f[8];
            end
        end else if (modrm_class(op, m32) != C_ACC_NONE) begin
            f = window_byte(it, i);
            over |= f[8];
            acc = (f[7:6] == C_MOD_REG) ? C_ACC_NONE : modrm_class(op, m32);
        end else if (op inside {8'h06, 8'h0E, 8'h16, 8'h1E, 8'h60}) begin
            acc = m32 ? (C_ACC_W | C_ACC_S) : C_ACC_NONE;
        end else if (op inside {8'h07, 8'h17, 8'h1F, 8'h61}) begin
            acc = m32 ? (C_ACC_R | C_ACC_S) : C_ACC_NONE;
        end else if (op inside {[8'h50:8'h57], 8'h68, 8'h6A, 8'h9C, 8'hC8, 8'hE8}) begin
            acc = C_ACC_W | C_ACC_S;
        end else if (op inside {[8'h58:8'h5F], 8'h9D, 8'hC2, 8'hC3, 8'hC9, 8'hCA, 8'hCB,
                                8'hCF}) begin
            acc = C_ACC_R | C_ACC_S;
        end else if (op inside {8'hA0, 8'hA1, 8'hA6, 8'hA7, 8'hAC, 8'hAD, 8'hAE, 8'hAF,
                                8'hD7}) begin
            acc = C_ACC_R;
        end else if (op inside {[8'hA2:8'hA5], 8'hAA, 8'hAB}) begin
            acc = C_ACC_W;
        end else if (op == C_OP_ESC_0F) begin
            // 66/F2/F3 ahead of 0F: no access, nothing further fetched
            if (!sse) begin
                f = window_byte(it, i);
                over |= f[8];
                op = f[7:0];
                if (op == 8'h00) begin
                    acc = C_ACC_R;
                end else if (op == 8'h01) begin
                    acc = C_ACC_W;
                end else if (op inside {8'hA0, 8'hA8}) begin
                    acc = C_ACC_W | C_ACC_S;
                end else if (op inside {8'hA1, 8'hA9}) begin
                    acc = C_ACC_R | C_ACC_S;
                end else begin
                    acc = map0f_class(op);
                    if (acc != C_ACC_NONE) begin
                        f = window_byte(it, i + 1);
                        over |= f[8];
                        if (f[7:6] == C_MOD_REG)
                            acc = C_ACC_NONE;
                    end
                end
            end
        end else if (op inside {[8'h80:8'h83], C_OP_POP_RM, 8'hF6, 8'hF7, 8'hFE, 8'hFF,
                                [8'hD8:8'hDF]}) begin
            f = window_byte(it, i);
            over |= f[8];
            m = f[7:0];
            if (op == C_OP_POP_RM) begin
                // POP r/m reports read and stack even in register form
                acc = C_ACC_R | C_ACC_S | ((m[7:6] != C_MOD_REG) ? C_ACC_W : C_ACC_NONE);
            end else if (m[7:6] == C_MOD_REG) begin
                acc = C_ACC_NONE;
            end else if (op <= 8'h83) begin
                // CMP (/7) only reads
                acc = C_ACC_R | ((m[5:3] != 3'd7) ? C_ACC_W : C_ACC_NONE);
            end else if (op inside {8'hF6, 8'hF7}) begin
                acc = (m[5:3] inside {3'd2, 3'd3}) ? C_ACC_W : C_ACC_R;
            end else if (op inside {8'hFE, 8'hFF}) begin
                if (m[5:3] inside {3'd0, 3'd1})
                    acc = C_ACC_W;
                else if (m[5:3] inside {3'd2, 3'd3, 3'd6})
                    acc = C_ACC_R | C_ACC_W | C_ACC_S;
                else
                    acc = C_ACC_R;
            end else begin
                acc = x87_class(op, m[5:3]);
            end
        end

        res.reads_memory  = (acc & C_ACC_R) != C_ACC_NONE;
        res.writes_memory = (acc & C_ACC_W) != C_ACC_NONE;
        res.uses_stack    = (acc & C_ACC_S) != C_ACC_NONE;
        res.overlong      = over;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    // Queue one window; bytes are given with byte 0 in bits 7:0
    function automatic void add_insn(bit m32, bit readable, logic [119:0] bytes);
        t_window_entry e;
        e.drain = 1'b0;
        e.beat.window_low    = bytes[63:0];
        e.beat.window_high   = bytes[119:64];
        e.beat.mode_32bit    = m32;
        e.beat.page_readable = readable;
        window_queue.push_back(e);
    endfunction

    function automatic void add_drain();
        t_window_entry e;
        e.drain = 1'b1;
        e.beat = '0;
        window_queue.push_back(e);
    endfunction

    function automatic logic [7:0] random_prefix();
        case ($urandom_range(0, 10))
            0:       return C_PFX_OPSZ;
            1:       return C_PFX_REPNE;
            2:       return C_PFX_REP;
            3:       return C_PFX_LOCK;
            4:       return C_PFX_CS;
            5:       return C_PFX_SS;
            6:       return C_PFX_DS;
            7:       return C_PFX_ES;
            8:       return C_PFX_FS;
            9:       return C_PFX_GS;
            default: return {C_PFX_REX_HI, 4'($urandom_range(0, 15))};
        endcase
    endfunction

    // Mostly well-formed instructions with random content, some long prefix
    // runs that spill past the window, and a little pure noise
    function automatic logic [119:0] random_window();
        logic [127:0] raw;
        logic [119:0] w;
        int           kind;
        int           n;
        raw = {$urandom, $urandom, $urandom, $urandom};
        w = raw[119:0];
        kind = $urandom_range(0, 99);
        if (kind < 5)
            return w;
        if (kind < 12)
            n = $urandom_range(10, 15);
        else if (kind < 45)
            n = 0;
        else
            n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++)
            w[8*k +: 8] = random_prefix();
        // Steer a quarter of the opcodes into the 0F map
        if (n < C_WINDOW_BYTES && $urandom_range(0, 3) == 0)
            w[8*n +: 8] = C_OP_ESC_0F;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of beats with random gaps; hold the payload while stalled
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_access.push_back(classify_insn(in_data));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (window_queue.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (window_queue[0].drain) begin
                    // Pause until every expected result has been delivered
                    in_valid <= 1'b0;
                    if (!in_valid && expected_access.size() == 0)
                        window_queue.delete(0);
                end else begin
                    in_data  <= window_queue[0].beat;
                    in_valid <= 1'b1;
                    window_queue.delete(0);
                    if (burst_left > 1) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        // Start a new burst; some are long stretches with no gaps
                        burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                                  : $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: a style redrawn at random whenever rx_cycle[5:0] is zero, plus one long
    // hold-off once the run is under way so the block fills and stalls its input
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (!hold_done && accepted_cnt >= HOLD_TRIGGER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            out_stall <= 1'b1;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle[5:0] == 6'd0)
                rx_style <= $urandom_range(0, 3);
            case (rx_style)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= rx_cycle[2];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each delivered beat with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_access.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result beat: r%0b w%0b s%0b o%0b",
                             out_data.reads_memory, out_data.writes_memory,
                             out_data.uses_stack, out_data.overlong);
            end else begin
                want = expected_access.pop_front();
                if (want.reads_memory  !== out_data.reads_memory  ||
                    want.writes_memory !== out_data.writes_memory ||
                    want.uses_stack    !== out_data.uses_stack    ||
                    want.overlong      !== out_data.overlong) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("mismatch: exp r%0b w%0b s%0b o%0b, got r%0b w%0b s%0b o%0b",
                                 want.reads_memory, want.writes_memory, want.uses_stack,
                                 want.overlong, out_data.reads_memory, out_data.writes_memory,
                                 out_data.uses_stack, out_data.overlong);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [127:0] raw;

        // Field extremes and the page-not-readable case
        add_insn(1'b0, 1'b1, '0);
        add_insn(1'b1, 1'b1, '1);
        raw = {$urandom, $urandom, $urandom, $urandom};
        add_insn(1'b0, 1'b0, raw[119:0]);
        // Prefix run filling the window: opcode and ModRM both fall past it
        add_insn(1'b0, 1'b1, {15{C_PFX_OPSZ}});
        // REX 4F is a prefix in 64-bit code, DEC in 32-bit code
        add_insn(1'b0, 1'b1, 120'h00_89_4F);
        add_insn(1'b1, 1'b1, 120'h00_89_4F);
        // SSE prefix ahead of 0F versus the plain 0F form
        add_insn(1'b0, 1'b1, 120'h00_10_0F_66);
        add_insn(1'b0, 1'b1, 120'h00_10_0F);
        // VEX at the last window byte: 32-bit peeks past the window, 64-bit does not
        add_insn(1'b1, 1'b1, {C_OP_VEX3, {14{C_PFX_DS}}});
        add_insn(1'b0, 1'b1, {C_OP_VEX2, {14{C_PFX_DS}}});
        // Three-byte escape map
        add_insn(1'b0, 1'b1, 120'h00_38_0F);
        // POP r/m register form keeps read and stack
        add_insn(1'b0, 1'b1, 120'hC0_8F);
        add_insn(1'b0, 1'b1, 120'h00_8F);
        // Segment push and ARPL/MOVSXD differ by mode
        add_insn(1'b1, 1'b1, 120'h06);
        add_insn(1'b0, 1'b1, 120'h06);
        add_insn(1'b1, 1'b1, 120'h00_63);
        add_insn(1'b0, 1'b1, 120'h00_63);
        // Indirect call through memory, plain push
        add_insn(1'b0, 1'b1, 120'h10_FF);
        add_insn(1'b0, 1'b1, 120'h50);
        // 0F escape at the last window byte: second opcode reads as zero
        add_insn(1'b0, 1'b1, {C_OP_ESC_0F, {14{C_PFX_CS}}});
        // Every reg field of the DD group in memory form
        for (int r = 0; r < 8; r++)
            add_insn(1'b1, 1'b1, {104'h0, 2'b00, 3'(r), 3'b000, 8'hDD});

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Sender pauses for a full drain twice, well clear of the hold-off
            if (n == 700 || n == 1050)
                add_drain();
            add_insn(1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0, random_window());
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Sample on the falling edge so queue and valid are settled
        do
            @(negedge clk);
        while (window_queue.size() != 0 || in_valid || expected_access.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0 && expected_access.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
